/* rtl/core/sci_pkg.sv */
// Shared constants and types for the segment versus circle intersection test.
`timescale 1ns / 1ps

package sci_pkg;

	// Default coordinate width
	localparam int COORD_BITS_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEG_START_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEG_START_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEG_END_X   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEG_END_Y   = 2'd3;

	// Decision flags carried alongside the wide products
	typedef struct packed {
		logic qa_pos;    // segment has non-zero length
		logic upper_ok;  // larger root not below zero
		logic lower_ok;  // smaller root not above one
		logic qc_neg;    // constant term negative
	} flags_t;

endpackage

/* rtl/core/segment_circle_intersect_test_core.sv */
// Top level of the segment versus circle intersection test pipeline.
`timescale 1ns / 1ps

// Takes one circle per clock cycle while s_tready is high and returns one
// hit flag per circle, through seven register stages: input difference,
// component products, coefficient sums, magnitudes and range flags, the two
// stages of the split wide multipliers for the discriminant terms, and the
// final compare. Each stage holds its own valid bit and fills empty slots
// while a result waits, so the pipeline keeps accepting until every stage is
// full. The user must write the segment end points through the configuration
// port only while no circle is in flight; the block does not enforce this.
// A tangent circle and a zero-length segment both report no hit.
module segment_circle_intersect_test_core #(
	parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [sci_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_wdata,
	// circle stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// center_x, center_y, radius, zero pad (from bit 0 up)
	input  logic [((3*COORD_BITS-1+7)/8)*8-1:0] s_tdata,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// hit, zero pad (from bit 0 up)
	output logic [7:0]                          m_tdata
);
	import sci_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int DW = N + 1;
	localparam int SW = 2 * N + 3;
	localparam int MW = 2 * N + 2;
	localparam int HW = N + 1;
	localparam int LW = SW + 2;
	localparam int XW = 4 * HW;

	// Segment end points
	logic signed [N-1:0] seg_start_x_q, seg_start_y_q, seg_end_x_q, seg_end_y_q;

	// Stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	logic signed [DW-1:0] dx_s1, dy_s1, fx_s1, fy_s1;
	logic        [N-2:0]  r_s1;
	logic signed [N-1:0]  cx, cy;

	logic signed [SW-1:0] qa_s3, dot_s3, qc_s3;
	logic signed [LW-1:0] tq, uq;

	logic [MW-1:0] mqa_s4, mdot_s4, mqc_s4;
	flags_t        flags_s4, flags_s5, flags_s6;

	logic [XW-1:0] dot2_s6, prod_s6;
	logic          hit_s7, disc_pos;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_x_q <= '0;
			seg_start_y_q <= '0;
			seg_end_x_q   <= '0;
			seg_end_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEG_START_X: seg_start_x_q <= cfg_wdata;
				REG_SEG_START_Y: seg_start_y_q <= cfg_wdata;
				REG_SEG_END_X:   seg_end_x_q   <= cfg_wdata;
				REG_SEG_END_Y:   seg_end_y_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances
	assign en_s7 = !v_s7 || m_tready;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	assign cx = s_tdata[N-1:0];
	assign cy = s_tdata[2*N-1:N];

	// Take the transaction and form segment direction and start offset
	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= DW'(seg_end_x_q) - DW'(seg_start_x_q);
			dy_s1 <= DW'(seg_end_y_q) - DW'(seg_start_y_q);
			fx_s1 <= DW'(seg_start_x_q) - DW'(cx);
			fy_s1 <= DW'(seg_start_y_q) - DW'(cy);
			r_s1  <= s_tdata[3*N-2:2*N];
		end
	end

	sci_coef #(
		.COORD_BITS(COORD_BITS)
	) u_coef (
		.clk     (clk),
		.en_prod (en_s2),
		.en_sum  (en_s3),
		.dx      (dx_s1),
		.dy      (dy_s1),
		.fx      (fx_s1),
		.fy      (fy_s1),
		.r       (r_s1),
		.qa      (qa_s3),
		.dot     (dot_s3),
		.qc      (qc_s3)
	);

	// Root range tests: t2 >= 0 and t1 <= 1
	assign tq = LW'(qa_s3) + LW'(dot_s3);
	assign uq = tq + LW'(dot_s3) + LW'(qc_s3);

	// Take magnitudes for the discriminant and settle the range flags
	always_ff @(posedge clk) begin
		if (en_s4) begin
			mqa_s4            <= MW'(qa_s3);
			mdot_s4           <= MW'(dot_s3[SW-1] ? -dot_s3 : dot_s3);
			mqc_s4            <= MW'(qc_s3[SW-1] ? -qc_s3 : qc_s3);
			flags_s4.qa_pos   <= (qa_s3 != '0);
			flags_s4.upper_ok <= (qc_s3 <= 0) || dot_s3[SW-1];
			flags_s4.lower_ok <= (uq <= 0) || (tq > 0);
			flags_s4.qc_neg   <= qc_s3[SW-1];
		end
	end

	sci_umul #(
		.HW(HW)
	) u_dot2 (
		.clk     (clk),
		.en_part (en_s5),
		.en_sum  (en_s6),
		.a       (mdot_s4),
		.b       (mdot_s4),
		.p       (dot2_s6)
	);

	sci_umul #(
		.HW(HW)
	) u_ac (
		.clk     (clk),
		.en_part (en_s5),
		.en_sum  (en_s6),
		.a       (mqa_s4),
		.b       (mqc_s4),
		.p       (prod_s6)
	);

	// Carry flags alongside the multipliers
	always_ff @(posedge clk) begin
		if (en_s5) flags_s5 <= flags_s4;
		if (en_s6) flags_s6 <= flags_s5;
	end

	// Strictly positive quarter discriminant dot^2 - a*c
	assign disc_pos = flags_s6.qc_neg ? ((dot2_s6 != '0) || (prod_s6 != '0))
	                                  : (dot2_s6 > prod_s6);

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk) begin
		if (en_s7) begin
			hit_s7 <= flags_s6.qa_pos && disc_pos && flags_s6.upper_ok && flags_s6.lower_ok;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {7'b0, hit_s7};

	// Input blocked only when the output holds a waiting result
	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output stage");

	// A held mid-pipeline item is neither lost nor dropped
	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s4) |=> v_s3)
		else $error("stage three item lost while stalled");

	// Zero-length segment implies zero projection term
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !flags_s4.qa_pos) |-> (mdot_s4 == '0))
		else $error("non-zero dot product on zero-length segment");

endmodule

/* rtl/core/sci_coef.sv */
// Quadratic coefficient stages: component products, then the three coefficients.
`timescale 1ns / 1ps

module sci_coef #(
	parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en_prod,
	input  logic                         en_sum,
	input  logic signed [COORD_BITS:0]   dx,
	input  logic signed [COORD_BITS:0]   dy,
	input  logic signed [COORD_BITS:0]   fx,
	input  logic signed [COORD_BITS:0]   fy,
	input  logic        [COORD_BITS-2:0] r,
	output logic signed [2*COORD_BITS+2:0] qa,
	output logic signed [2*COORD_BITS+2:0] dot,
	output logic signed [2*COORD_BITS+2:0] qc
);
	import sci_pkg::*;

	localparam int PW = 2 * COORD_BITS + 2;
	localparam int SW = PW + 1;
	localparam int RW = 2 * COORD_BITS - 2;

	logic signed [PW-1:0] dxdx_s2, dydy_s2, dxfx_s2, dyfy_s2, fxfx_s2, fyfy_s2;
	logic        [RW-1:0] rr_s2;

	// Form the component products
	always_ff @(posedge clk) begin
		if (en_prod) begin
			dxdx_s2 <= PW'(dx) * PW'(dx);
			dydy_s2 <= PW'(dy) * PW'(dy);
			dxfx_s2 <= PW'(dx) * PW'(fx);
			dyfy_s2 <= PW'(dy) * PW'(fy);
			fxfx_s2 <= PW'(fx) * PW'(fx);
			fyfy_s2 <= PW'(fy) * PW'(fy);
			rr_s2   <= RW'(r) * RW'(r);
		end
	end

	// Sum into a = |d|^2, dot = d.f, c = |f|^2 - r^2
	always_ff @(posedge clk) begin
		if (en_sum) begin
			qa  <= SW'(dxdx_s2) + SW'(dydy_s2);
			dot <= SW'(dxfx_s2) + SW'(dyfy_s2);
			qc  <= SW'(fxfx_s2) + SW'(fyfy_s2) - SW'($signed({1'b0, rr_s2}));
		end
	end

endmodule

/* rtl/core/sci_umul.sv */
// Unsigned wide multiplier split into half-width partial products over two stages.
`timescale 1ns / 1ps

module sci_umul #(
	parameter int HW = sci_pkg::COORD_BITS_DEF + 1
) (
	input  logic            clk,
	input  logic            en_part,
	input  logic            en_sum,
	input  logic [2*HW-1:0] a,
	input  logic [2*HW-1:0] b,
	output logic [4*HW-1:0] p
);
	import sci_pkg::*;

	localparam int PW = 4 * HW;
	localparam int FW = 2 * HW;

	logic [2*HW-1:0] hh_s1, hl_s1, lh_s1, ll_s1;

	// Form the four half-width partial products
	always_ff @(posedge clk) begin
		if (en_part) begin
			hh_s1 <= FW'(a[2*HW-1:HW]) * FW'(b[2*HW-1:HW]);
			hl_s1 <= FW'(a[2*HW-1:HW]) * FW'(b[HW-1:0]);
			lh_s1 <= FW'(a[HW-1:0]) * FW'(b[2*HW-1:HW]);
			ll_s1 <= FW'(a[HW-1:0]) * FW'(b[HW-1:0]);
		end
	end

	// Align and add the partial products
	always_ff @(posedge clk) begin
		if (en_sum) begin
			p <= (PW'(hh_s1) << (2 * HW)) + ((PW'(hl_s1) + PW'(lh_s1)) << HW) + PW'(ll_s1);
		end
	end

endmodule

/* sim/segment_circle_intersect_test_core_test.sv */
// Testbench for the segment versus circle intersection test core.
`timescale 1ns / 1ps

module segment_circle_intersect_test_core_test;
	import sci_pkg::*;

	localparam int COORD_BITS      = 16;
	localparam int DATA_W          = ((3*COORD_BITS-1+7)/8)*8;
	localparam int LATENCY         = 7;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int SEGMENT_KINDS   = 8;
	localparam int ITEMS_PER_KIND  = 56;
	localparam int IDLE_PERCENT    = 36;
	localparam int MAX_REPORTS     = 10;
	localparam int DIRECTED_ROWS   = 22;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-2:0]        radius_t;
	typedef logic signed [127:0]          wide_t;

	typedef struct packed {
		coord_t  cx;
		coord_t  cy;
		radius_t rad;
	} circle_t;

	typedef struct packed {
		int seg;
		int cx;
		int cy;
		int rad;
		bit known;
		bit hit;
	} directed_row_t;

	typedef struct packed {
		int item;
		bit hit;
	} hit_expect_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0]   cfg_wdata;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [DATA_W-1:0]       s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [7:0]              m_tdata;

	// segment as currently loaded into the block
	coord_t seg_ax, seg_ay, seg_bx, seg_by;

	hit_expect_t expected_hits [$];
	int circles_sent;
	int results_seen;
	int hits_seen;
	int mismatches;
	int segments_loaded;
	int cycle_count;
	bit no_gaps;
	bit no_stalls;

	// Segments used by the directed rows; entry 0 is the state after reset
	int seg_table [4][4] = '{
		'{0, 0, 0, 0},
		'{-100, 0, 100, 0},
		'{-32768, -32768, 32767, 32767},
		'{5, -7, 5, -7}
	};

	// seg, center x, center y, radius, hit typed in, typed hit
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{0, 0, 0, 32767, 1'b1, 1'b0},
		'{0, -32768, -32768, 0, 1'b1, 1'b0},
		'{0, 32767, 32767, 32767, 1'b1, 1'b0},
		'{1, 0, 10, 10, 1'b1, 1'b0},
		'{1, 0, 10, 11, 1'b1, 1'b1},
		'{1, 0, 0, 5, 1'b1, 1'b1},
		'{1, 0, 0, 1000, 1'b1, 1'b1},
		'{1, 300, 0, 100, 1'b0, 1'b0},
		'{1, 200, 0, 100, 1'b0, 1'b0},
		'{1, -200, 0, 100, 1'b0, 1'b0},
		'{1, 0, -101, 100, 1'b0, 1'b0},
		'{1, 0, 32767, 32767, 1'b0, 1'b0},
		'{1, -32768, -32768, 32767, 1'b0, 1'b0},
		'{1, 32767, -32768, 0, 1'b0, 1'b0},
		'{2, 0, 0, 0, 1'b1, 1'b0},
		'{2, 0, 0, 1, 1'b1, 1'b1},
		'{2, 32767, -32768, 32767, 1'b0, 1'b0},
		'{2, -32768, 32767, 16384, 1'b0, 1'b0},
		'{2, 32767, 32767, 0, 1'b0, 1'b0},
		'{3, 5, -7, 32767, 1'b1, 1'b0},
		'{3, 5, -7, 0, 1'b1, 1'b0},
		'{3, -32768, 32767, 100, 1'b1, 1'b0}
	};

	segment_circle_intersect_test_core #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Decide exactly whether the circle meets the loaded segment
	function automatic bit circle_meets_segment(circle_t c);
		longint dx, dy, fx, fy, qa, dot, qc, vertex, q_one;
		wide_t  wide_dot, wide_qa, wide_qc, disc;
		bit     upper_ok, lower_ok;
		dx  = longint'(seg_bx) - longint'(seg_ax);
		dy  = longint'(seg_by) - longint'(seg_ay);
		fx  = longint'(seg_ax) - longint'(c.cx);
		fy  = longint'(seg_ay) - longint'(c.cy);
		qa  = dx*dx + dy*dy;
		dot = dx*fx + dy*fy;
		qc  = fx*fx + fy*fy - longint'(c.rad) * longint'(c.rad);
		// zero-length segment never hits
		if (qa <= 0)
			return 1'b0;
		wide_dot = dot;
		wide_qa  = qa;
		wide_qc  = qc;
		disc = wide_dot*wide_dot - wide_qa*wide_qc;
		// tangency counts as a miss
		if (disc <= 0)
			return 1'b0;
		upper_ok = (qc <= 0) || (dot < 0);
		vertex   = qa + dot;
		q_one    = vertex + dot + qc;
		lower_ok = (q_one <= 0) || (vertex > 0);
		return upper_ok && lower_ok;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > 32767)
			return coord_t'(32767);
		if (v < -32768)
			return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	// Mix full-range circles with circles placed close to the segment
	function automatic circle_t random_circle();
		circle_t c;
		longint  px, py, t;
		int      mode, span;
		mode = $urandom_range(0, 9);
		span = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 8192);
		if (mode < 4) begin
			c.cx  = coord_t'($urandom);
			c.cy  = coord_t'($urandom);
			c.rad = radius_t'($urandom);
		end else begin
			if (mode < 8) begin
				t  = $urandom_range(0, 1024);
				px = longint'(seg_ax) + (longint'(seg_bx) - longint'(seg_ax)) * t / 1024;
				py = longint'(seg_ay) + (longint'(seg_by) - longint'(seg_ay)) * t / 1024;
			end else if (mode == 8) begin
				px = seg_ax;
				py = seg_ay;
			end else begin
				px = seg_bx;
				py = seg_by;
			end
			c.cx  = clamp_coord(px + longint'($urandom_range(0, 2*span)) - span);
			c.cy  = clamp_coord(py + longint'($urandom_range(0, 2*span)) - span);
			c.rad = radius_t'($urandom_range(0, 2*span));
		end
		return c;
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Drop valid and hold until every outstanding result has arrived
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_hits.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_SEG_START_X: seg_ax = val;
			REG_SEG_START_Y: seg_ay = val;
			REG_SEG_END_X:   seg_bx = val;
			REG_SEG_END_Y:   seg_by = val;
			default: ;
		endcase
	endtask

	task automatic set_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		wait_idle();
		write_reg(REG_SEG_START_X, ax);
		write_reg(REG_SEG_START_Y, ay);
		write_reg(REG_SEG_END_X, bx);
		write_reg(REG_SEG_END_Y, by);
		cfg_we <= 1'b0;
		@(posedge clk);
		segments_loaded++;
	endtask

	// Choose a segment of the given kind and load it
	task automatic load_segment_kind(int kind);
		coord_t ax, ay, bx, by;
		ax = coord_t'($urandom);
		ay = coord_t'($urandom);
		bx = coord_t'($urandom);
		by = coord_t'($urandom);
		case (kind)
			0: begin
				bx = ax;
				by = ay;
			end
			1: begin
				ax = coord_t'(-32768);
				ay = coord_t'(-32768);
				bx = coord_t'(32767);
				by = coord_t'(32767);
			end
			2: begin
				ax = coord_t'(32767);
				ay = coord_t'(-32768);
				bx = coord_t'(-32768);
				by = coord_t'(32767);
			end
			4: begin
				bx = clamp_coord(longint'(ax) + $urandom_range(0, 400) - 200);
				by = clamp_coord(longint'(ay) + $urandom_range(0, 400) - 200);
			end
			5: by = ay;
			6: bx = ax;
			default: ;
		endcase
		set_segment(ax, ay, bx, by);
	endtask

	// Offer one circle, hold it until accepted and record the expected hit
	task automatic send_circle(circle_t c, bit known, bit known_hit);
		hit_expect_t e;
		if (!no_gaps) begin
			while ($urandom_range(0, 99) < IDLE_PERCENT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= DATA_W'({c.rad, c.cy, c.cx});
		do
			@(posedge clk);
		while (!s_tready);
		e.item = circles_sent;
		e.hit  = known ? known_hit : circle_meets_segment(c);
		expected_hits.push_back(e);
		circles_sent++;
	endtask

	// Check each result transaction against the oldest expectation, then pick ready
	always @(posedge clk) begin : result_check
		hit_expect_t exp_hit;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tdata[0])
					hits_seen++;
				if (expected_hits.size() == 0) begin
					note_mismatch($sformatf("result hit=%0b with nothing expected", m_tdata[0]));
				end else begin
					exp_hit = expected_hits.pop_front();
					if (m_tdata[0] !== exp_hit.hit)
						note_mismatch($sformatf("circle %0d: hit expected %0b, got %0b",
							exp_hit.item, exp_hit.hit, m_tdata[0]));
				end
			end
			m_tready <= no_stalls || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_hits.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		circle_t c;
		int      cur_seg;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		seg_ax    = '0;
		seg_ay    = '0;
		seg_bx    = '0;
		seg_by    = '0;
		no_gaps   = 1'b0;
		no_stalls = 1'b0;
		cycle_count     = 0;
		circles_sent    = 0;
		results_seen    = 0;
		hits_seen       = 0;
		mismatches      = 0;
		segments_loaded = 0;
		cur_seg         = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, reloading the segment where the row asks
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].seg != cur_seg) begin
				cur_seg = directed_rows[i].seg;
				set_segment(coord_t'(seg_table[cur_seg][0]), coord_t'(seg_table[cur_seg][1]),
					coord_t'(seg_table[cur_seg][2]), coord_t'(seg_table[cur_seg][3]));
			end
			c.cx  = coord_t'(directed_rows[i].cx);
			c.cy  = coord_t'(directed_rows[i].cy);
			c.rad = radius_t'(directed_rows[i].rad);
			send_circle(c, directed_rows[i].known, directed_rows[i].hit);
		end

		// Random circles against one segment of each kind; one kind runs without idling
		for (int kind = 0; kind < SEGMENT_KINDS; kind++) begin
			load_segment_kind(kind);
			no_gaps   = (kind == 5);
			no_stalls = (kind == 5);
			repeat (ITEMS_PER_KIND)
				send_circle(random_circle(), 1'b0, 1'b0);
		end
		no_gaps   = 1'b0;
		no_stalls = 1'b0;

		wait_idle();
		repeat (4*LATENCY) @(posedge clk);

		$display("Checked %0d circles (%0d hits) against %0d segment settings,",
			results_seen, hits_seen, segments_loaded);
		$display("covering tangency, zero-length and full-range segments; %0d mismatches",
			mismatches);
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* segment_circle_intersect_test_core.f */
rtl/core/sci_pkg.sv
rtl/core/sci_coef.sv
rtl/core/sci_umul.sv
rtl/core/segment_circle_intersect_test_core.sv
sim/segment_circle_intersect_test_core_test.sv
